// File: rtl/core/iat_pkg.sv
package iat_pkg;

    // Field widths fixed by the stream format
    localparam int SEQ_W       = 16;
    localparam int STAMP_W     = 32;
    localparam int CNT_W       = 32;
    localparam int TIMEOUT_W   = 16;
    localparam int ACK_COUNT_W = 9;
    localparam int KIND_W      = 3;
    localparam int IN_FLIGHT_W = 7;
    localparam int OP_W        = 2;

    // Input word layout
    localparam int S_TDATA_W = 32;
    localparam int OP_LSB    = 0;
    localparam int START_LSB = OP_LSB + OP_W;
    localparam int COUNT_LSB = START_LSB + SEQ_W;

    // Output word layout
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = KIND_W;

    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET = 16'd30;
    localparam logic [ACK_COUNT_W-1:0] ACK_COUNT_MAX = 9'd256;

    // Cap on retired entries per input word
    localparam int RES_CNT_W   = 7;
    localparam int MAX_RESULTS = 64;

    typedef enum logic [OP_W-1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ASSIGNED  = 3'd0,
        KIND_DELIVERED = 3'd1,
        KIND_DROPPED   = 3'd2,
        KIND_NONE      = 3'd3,
        KIND_REFUSED   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic take_item;
        logic do_send;
        logic retire_drop;
        logic retire_deliver;
        logic skip_ahead;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic walk_more;
        logic head_below;
        logic head_equal;
        logic out_free;
        logic pend_valid;
    } dp_status_t;

endpackage

// File: rtl/core/inflight_ack_tracker_core.sv
// channel | dir | handshake          | payload
// --------+-----+--------------------+-----------------------------------------------
// s_      | in  | s_tvalid/s_tready  | tdata: operation, ack_start, ack_count
// m_      | out | m_tvalid/m_tready  | tdata: sequence_res, totals, in_flight;
//         |     |                    | tuser: kind; tlast: last
// cfg_    | in  | cfg_wr_en          | cfg_wr_data: timeout_ticks
//
// A send or an idle operation goes from acceptance through load, evaluate and flush
// back to idle. Ack and tick words add a load and evaluate step per retired entry and
// an evaluate step per skip-ahead, set by the in-flight queue memory's single registered read port.
// Reset (aresetn low, synchronous) empties the queue and clears the counters; the
// queue memory itself is not cleared. A stalled m_ side holds the walk, while the
// next input word is still accepted once the final result sits in the output register.
module inflight_ack_tracker_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] operation, [17:2] ack_start, [26:18] ack_count, [31:27] zero
    input  logic [iat_pkg::S_TDATA_W-1:0]   s_tdata,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] sequence_res, [47:16] delivered_total, [79:48] dropped_total,
    // [86:80] in_flight, [87] zero
    output logic [iat_pkg::M_TDATA_W-1:0]   m_tdata,
    // [2:0] kind
    output logic [iat_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast,

    input  logic                            cfg_wr_en,
    input  logic [iat_pkg::TIMEOUT_W-1:0]   cfg_wr_data
);
    import iat_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // Sequencer: accept a word, then step the head walk one entry at a time
    iat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Queue memory, counters, pending result and output register
    iat_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// File: rtl/core/iat_ctrl.sv
module iat_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  iat_pkg::dp_status_t    sts,
    output iat_pkg::ctrl_cmd_t     cmd
);
    import iat_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            // wait for the head entry read
            ST_LOAD: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (sts.op == OP_SEND) begin
                    cmd.do_send = 1'b1;
                    state_next  = ST_FLUSH;
                end else if (!sts.walk_more) begin
                    state_next = ST_FLUSH;
                end else if (sts.pend_valid && !sts.out_free) begin
                    state_next = ST_EVAL;
                end else if (sts.op == OP_TICK || sts.head_below) begin
                    cmd.retire_drop = 1'b1;
                    state_next      = ST_LOAD;
                end else if (sts.head_equal) begin
                    cmd.retire_deliver = 1'b1;
                    state_next         = ST_LOAD;
                end else begin
                    cmd.skip_ahead = 1'b1;
                    state_next     = ST_EVAL;
                end
            end
            ST_FLUSH: begin
                if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/iat_dp.sv
module iat_dp #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [iat_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            cfg_wr_en,
    input  logic [iat_pkg::TIMEOUT_W-1:0]   cfg_wr_data,
    input  iat_pkg::ctrl_cmd_t              cmd,
    output iat_pkg::dp_status_t             sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [iat_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [iat_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);
    import iat_pkg::*;

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = AW + 1;
    localparam int ACK_W = SEQ_W + 1;

    // In-flight queue storage
    logic [SEQ_W-1:0]   seq_mem   [QUEUE_DEPTH];
    logic [STAMP_W-1:0] stamp_mem [QUEUE_DEPTH];
    logic [SEQ_W-1:0]   rd_seq_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;

    logic [AW-1:0]        head_reg;
    logic [FW-1:0]        fill_reg;
    logic [SEQ_W-1:0]     next_seq_reg;
    logic [STAMP_W-1:0]   time_reg;
    logic [CNT_W-1:0]     dlv_reg;
    logic [CNT_W-1:0]     drp_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    op_t                  op_reg;
    logic [ACK_W-1:0]     acked_reg;
    logic [ACK_W-1:0]     end_reg;
    logic [RES_CNT_W-1:0] res_cnt_reg;

    // Result held back until it is known whether it is the final one
    logic                 pend_valid_reg;
    kind_t                pend_kind_reg;
    logic [SEQ_W-1:0]     pend_seq_reg;
    logic [CNT_W-1:0]     pend_dlv_reg;
    logic [CNT_W-1:0]     pend_drp_reg;
    logic [FW-1:0]        pend_fill_reg;

    logic                   m_tvalid_reg;
    kind_t                  out_kind_reg;
    logic [SEQ_W-1:0]       out_seq_reg;
    logic [CNT_W-1:0]       out_dlv_reg;
    logic [CNT_W-1:0]       out_drp_reg;
    logic [IN_FLIGHT_W-1:0] out_fill_reg;
    logic                   out_last_reg;

    logic [SW-1:0]          tail_sum;
    logic [AW-1:0]          tail_idx;
    logic [AW-1:0]          head_inc;
    logic                   queue_full;
    logic                   queue_empty;
    logic                   send_ok;
    logic                   retire;
    logic                   out_free;
    logic [ACK_W-1:0]       head_seq_ext;
    logic [STAMP_W:0]       stamp_limit;
    logic                   expired;
    logic                   room;
    logic                   walk_more;
    logic [FW-1:0]          fill_next;
    logic [CNT_W-1:0]       dlv_next;
    logic [CNT_W-1:0]       drp_next;
    logic [ACK_COUNT_W-1:0] count_in;
    logic [ACK_COUNT_W-1:0] count_sat;
    logic [SEQ_W-1:0]       start_in;

    assign tail_sum = SW'(head_reg) + SW'(fill_reg);
    assign tail_idx = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : AW'(tail_sum);
    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign queue_full  = (fill_reg == FW'(QUEUE_DEPTH));
    assign queue_empty = (fill_reg == '0);
    assign send_ok     = cmd.do_send && !queue_full;
    assign retire      = cmd.retire_drop || cmd.retire_deliver;
    assign out_free    = !m_tvalid_reg || m_tready;

    assign head_seq_ext = {1'b0, rd_seq_reg};
    assign stamp_limit  = {1'b0, rd_stamp_reg} + {{(STAMP_W + 1 - TIMEOUT_W){1'b0}}, timeout_reg};
    assign expired      = stamp_limit < {1'b0, time_reg};
    assign room         = res_cnt_reg < RES_CNT_W'(MAX_RESULTS);

    always_comb begin
        case (op_reg)
            OP_ACK:  walk_more = (acked_reg < end_reg) && !queue_empty && room;
            OP_TICK: walk_more = !queue_empty && room && expired;
            default: walk_more = 1'b0;
        endcase
    end

    assign fill_next = send_ok ? fill_reg + 1'b1 : (retire ? fill_reg - 1'b1 : fill_reg);
    assign dlv_next  = dlv_reg + CNT_W'(cmd.retire_deliver);
    assign drp_next  = drp_reg + CNT_W'(cmd.retire_drop);

    assign start_in  = s_tdata[START_LSB +: SEQ_W];
    assign count_in  = s_tdata[COUNT_LSB +: ACK_COUNT_W];
    assign count_sat = (count_in > ACK_COUNT_MAX) ? ACK_COUNT_MAX : count_in;

    assign sts.op         = op_reg;
    assign sts.walk_more  = walk_more;
    assign sts.head_below = head_seq_ext < acked_reg;
    assign sts.head_equal = head_seq_ext == acked_reg;
    assign sts.out_free   = out_free;
    assign sts.pend_valid = pend_valid_reg;

    // Queue memory: write at the tail, registered read at the head
    always_ff @(posedge aclk) begin
        if (send_ok) begin
            seq_mem[tail_idx]   <= next_seq_reg;
            stamp_mem[tail_idx] <= time_reg;
        end
        rd_seq_reg   <= seq_mem[head_reg];
        rd_stamp_reg <= stamp_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            fill_reg       <= '0;
            next_seq_reg   <= '0;
            time_reg       <= '0;
            dlv_reg        <= '0;
            drp_reg        <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (cmd.take_item && op_t'(s_tdata[OP_LSB +: OP_W]) == OP_TICK) begin
                time_reg <= time_reg + 1'b1;
            end
            if (send_ok) begin
                next_seq_reg <= next_seq_reg + 1'b1;
            end
            if (retire) begin
                head_reg <= head_inc;
            end
            fill_reg <= fill_next;
            dlv_reg  <= dlv_next;
            drp_reg  <= drp_next;

            if (retire || cmd.do_send) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush || cmd.take_item) begin
                pend_valid_reg <= 1'b0;
            end

            if (cmd.flush || (retire && pend_valid_reg)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item registers and result payload
    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            op_reg      <= op_t'(s_tdata[OP_LSB +: OP_W]);
            acked_reg   <= ACK_W'(start_in);
            end_reg     <= ACK_W'(start_in) + ACK_W'(count_sat);
            res_cnt_reg <= '0;
        end else begin
            if (retire) begin
                res_cnt_reg <= res_cnt_reg + 1'b1;
            end
            if (cmd.retire_deliver) begin
                acked_reg <= acked_reg + 1'b1;
            end else if (cmd.skip_ahead) begin
                acked_reg <= head_seq_ext;
            end
        end

        if (retire) begin
            pend_kind_reg <= cmd.retire_deliver ? KIND_DELIVERED : KIND_DROPPED;
            pend_seq_reg  <= rd_seq_reg;
            pend_dlv_reg  <= dlv_next;
            pend_drp_reg  <= drp_next;
            pend_fill_reg <= fill_next;
        end else if (cmd.do_send) begin
            pend_kind_reg <= queue_full ? KIND_REFUSED : KIND_ASSIGNED;
            pend_seq_reg  <= next_seq_reg;
            pend_dlv_reg  <= dlv_reg;
            pend_drp_reg  <= drp_reg;
            pend_fill_reg <= fill_next;
        end

        if (cmd.flush && !pend_valid_reg) begin
            out_kind_reg <= KIND_NONE;
            out_seq_reg  <= '0;
            out_dlv_reg  <= dlv_reg;
            out_drp_reg  <= drp_reg;
            out_fill_reg <= IN_FLIGHT_W'(fill_reg);
            out_last_reg <= 1'b1;
        end else if (cmd.flush || (retire && pend_valid_reg)) begin
            out_kind_reg <= pend_kind_reg;
            out_seq_reg  <= pend_seq_reg;
            out_dlv_reg  <= pend_dlv_reg;
            out_drp_reg  <= pend_drp_reg;
            out_fill_reg <= IN_FLIGHT_W'(pend_fill_reg);
            out_last_reg <= cmd.flush;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_fill_reg, out_drp_reg, out_dlv_reg, out_seq_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_retire_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        retire |-> !queue_empty)
        else $error("retire from empty queue");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.flush || (retire && pend_valid_reg)) |-> out_free)
        else $error("output register overwritten while held");

    a_pend_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_item |-> !pend_valid_reg)
        else $error("pending result left over from previous word");

endmodule
